// ===== rtl/ravs_pkg.sv =====
package ravs_pkg;

  localparam int RANGE_W   = 16;
  localparam int STAT_W    = 8;
  localparam int ELAP_W    = 16;
  localparam int MEAN_W    = 16;
  localparam int SCALE_W   = 10;
  localparam int SPEED_W   = 32;
  localparam int PROD_W    = MEAN_W + SCALE_W;
  localparam int FRAC_W    = 8;
  localparam int DVD_W     = PROD_W + FRAC_W;
  localparam int REM_W     = 16;
  localparam int DIV_STEPS = DVD_W / 2;
  localparam int CNT_W     = 5;
  localparam int IDX_W     = 4;
  localparam int CFG_W     = 10;
  localparam int S_DATA_W  = RANGE_W + ELAP_W;
  localparam int M_DATA_W  = MEAN_W + SPEED_W;
  localparam int M_USER_W  = 2;

  localparam logic [IDX_W-1:0] REG_REJECT_STATUS = 4'd0;
  localparam logic [IDX_W-1:0] REG_SPEED_SCALE   = 4'd1;

  localparam logic [STAT_W-1:0]  RST_REJECT_STATUS = 8'd4;
  localparam logic [SCALE_W-1:0] RST_SPEED_SCALE   = 10'd100;

  localparam logic [SPEED_W-1:0] SPEED_SAT = '1;

  typedef struct packed {
    logic capture;
    logic window_update;
    logic div_start;
    logic take_mean;
    logic do_mul;
    logic load_result;
  } ravs_cmd_t;

  typedef struct packed {
    logic reject;
    logic elapsed_zero;
    logic div_done;
    logic out_free;
  } ravs_sts_t;

  typedef enum logic [7:0] {
    ST_IDLE      = 8'b00000001,
    ST_READ      = 8'b00000010,
    ST_UPDATE    = 8'b00000100,
    ST_MEAN      = 8'b00001000,
    ST_MUL       = 8'b00010000,
    ST_SDIV_GO   = 8'b00100000,
    ST_SDIV_WAIT = 8'b01000000,
    ST_FINISH    = 8'b10000000
  } ravs_state_t;

endpackage

// ===== rtl/ravs_ram.sv =====
module ravs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 7
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/ravs_div.sv =====
module ravs_div import ravs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [REM_W-1:0] divisor,
  output logic [DVD_W-1:0] quotient,
  output logic             done
);

  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] dsr;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [REM_W:0]   r1, n1, r2, n2;
  logic             ge1, ge2;
  logic [DVD_W-1:0] q1, q2;

  // two restoring steps per cycle
  always_comb begin
    r1  = {rem, quotient[DVD_W-1]};
    ge1 = (r1 >= {1'b0, dsr});
    n1  = ge1 ? (r1 - {1'b0, dsr}) : r1;
    q1  = {quotient[DVD_W-2:0], ge1};
    r2  = {n1[REM_W-1:0], q1[DVD_W-1]};
    ge2 = (r2 >= {1'b0, dsr});
    n2  = ge2 ? (r2 - {1'b0, dsr}) : r2;
    q2  = {q1[DVD_W-2:0], ge2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dsr      <= divisor;
    end else if (busy) begin
      quotient <= q2;
      rem      <= n2[REM_W-1:0];
    end
  end

endmodule

// ===== rtl/ravs_dp.sv =====
module ravs_dp import ravs_pkg::*; #(
  parameter int DEPTH = 7
) (
  input  logic                clk,
  input  logic                rst,
  input  ravs_cmd_t           cmd,
  output ravs_sts_t           sts,
  input  logic [S_DATA_W-1:0] s_tdata,
  input  logic [STAT_W-1:0]   s_tuser,
  input  logic                cfg_valid,
  input  logic [IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,
  output logic [M_USER_W-1:0] m_tuser
);

  localparam int SLOT_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TOT_W   = RANGE_W + $clog2(DEPTH + 1);
  localparam int MEAN_SH = TOT_W + $clog2(DEPTH);
  localparam int RECIP_W = TOT_W + 1;
  localparam int MPROD_W = TOT_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << MEAN_SH) + 64'(DEPTH) - 64'd1) / 64'(DEPTH));

  logic [STAT_W-1:0]  reject_status;
  logic [SCALE_W-1:0] speed_scale;

  logic [RANGE_W-1:0] in_range;
  logic [STAT_W-1:0]  in_status;
  logic [ELAP_W-1:0]  in_elapsed;

  logic [DEPTH-1:0]   win_valid;
  logic [SLOT_W-1:0]  slot;
  logic [SLOT_W-1:0]  slot_next;
  logic [TOT_W-1:0]   total;
  logic [TOT_W-1:0]   total_next;
  logic [RANGE_W-1:0] ram_rdata;
  logic [RANGE_W-1:0] old_entry;

  logic [MPROD_W-1:0] mean_prod;
  logic [MEAN_W-1:0]  mean;
  logic [MEAN_W-1:0]  prev_mean;
  logic [MEAN_W-1:0]  diff;
  logic [PROD_W-1:0]  product;

  logic [DVD_W-1:0]   div_dividend;
  logic [REM_W-1:0]   div_divisor;
  logic [DVD_W-1:0]   div_q;
  logic               div_done;
  logic [SPEED_W-1:0] speed;

  // config writes are always taken
  always_ff @(posedge clk) begin
    if (rst) begin
      reject_status <= RST_REJECT_STATUS;
      speed_scale   <= RST_SPEED_SCALE;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_REJECT_STATUS: reject_status <= cfg_data[STAT_W-1:0];
        REG_SPEED_SCALE:   speed_scale   <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_range   <= s_tdata[RANGE_W-1:0];
      in_elapsed <= s_tdata[S_DATA_W-1:RANGE_W];
      in_status  <= s_tuser;
    end
  end

  ravs_ram #(.WIDTH(RANGE_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (cmd.window_update),
    .waddr (slot),
    .wdata (in_range),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  always_comb begin
    old_entry  = win_valid[slot] ? ram_rdata : '0;
    total_next = total - TOT_W'(old_entry) + TOT_W'(in_range);
    slot_next  = (slot == SLOT_W'(DEPTH - 1)) ? '0 : slot + 1'b1;
    diff       = (mean >= prev_mean) ? (mean - prev_mean) : (prev_mean - mean);
    // floor(total / DEPTH) by reciprocal multiply, exact over the whole sum range
    mean_prod  = MPROD_W'(total) * MPROD_W'(RECIP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_valid <= '0;
      slot      <= '0;
      total     <= '0;
    end else if (cmd.window_update) begin
      win_valid[slot] <= 1'b1;
      slot            <= slot_next;
      total           <= total_next;
    end
  end

  always_comb begin
    div_dividend = {product, FRAC_W'(0)};
    div_divisor  = in_elapsed;
  end

  ravs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_q),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.take_mean) begin
      mean <= mean_prod[MEAN_SH +: MEAN_W];
    end
    if (cmd.do_mul) begin
      product <= PROD_W'(diff) * PROD_W'(speed_scale);
    end
  end

  // saturate the speed when the elapsed time is zero or the quotient does not fit the speed field
  always_comb begin
    if (in_elapsed == '0) begin
      speed = SPEED_SAT;
    end else if (div_q[DVD_W-1:SPEED_W] != '0) begin
      speed = SPEED_SAT;
    end else begin
      speed = div_q[SPEED_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid  <= 1'b0;
      prev_mean <= '0;
    end else if (cmd.load_result) begin
      m_tvalid  <= 1'b1;
      prev_mean <= mean;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      m_tdata <= {speed, mean};
      m_tuser <= {(mean != prev_mean), (in_elapsed == '0)};
    end
  end

  always_comb begin
    sts.reject       = (in_status == reject_status);
    sts.elapsed_zero = (in_elapsed == '0);
    sts.div_done     = div_done;
    sts.out_free     = !m_tvalid || m_tready;
  end

endmodule

// ===== rtl/ravs_ctrl.sv =====
module ravs_ctrl import ravs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  ravs_sts_t sts,
  output ravs_cmd_t cmd
);

  ravs_state_t state;
  ravs_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    s_tready   = 1'b0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = ST_READ;
        end
      end
      // old entry comes out of the RAM
      ST_READ: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.window_update = !sts.reject;
        state_next        = ST_MEAN;
      end
      ST_MEAN: begin
        cmd.take_mean = 1'b1;
        state_next    = ST_MUL;
      end
      ST_MUL: begin
        cmd.do_mul = 1'b1;
        state_next = ST_SDIV_GO;
      end
      ST_SDIV_GO: begin
        if (sts.elapsed_zero) begin
          state_next = ST_FINISH;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = ST_SDIV_WAIT;
        end
      end
      ST_SDIV_WAIT: begin
        if (sts.div_done) begin
          state_next = ST_FINISH;
        end
      end
      // hold until the output register is free
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.load_result = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/range_average_and_speed_top.sv =====
// Each accepted input word gives one result word; the divider is skipped when elapsed_ms is 0.
// A new input word is taken only after the last one reaches the output register; the speed
//   comes from a radix-4 divider and the mean from a reciprocal multiply.
// The output register lets the next input word in while a result waits.
// Reset (rst, synchronous): window cleared through per-entry valid bits, slot, sum and
//   previous mean to zero, reject_status to 4, speed_scale to 100; no clearing pass.
module range_average_and_speed_top import ravs_pkg::*; #(
  parameter int DEPTH = 7
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // range_mm, elapsed_ms
  input  logic [STAT_W-1:0]   s_tuser,   // range_status
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,   // mean_distance, speed_fixed
  output logic [M_USER_W-1:0] m_tuser,   // elapsed_zero, mean_changed
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]    cfg_data
);

  ravs_cmd_t cmd;
  ravs_sts_t sts;

  assign cfg_ready = 1'b1;

  ravs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ravs_dp #(.DEPTH(DEPTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

// ===== rtl/ravs_checker.sv =====
module ravs_checker import ravs_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata,
  input logic [M_USER_W-1:0] m_tuser
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  // zero elapsed time always reports a saturated speed
  a_zero_sat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[M_DATA_W-1:MEAN_W] == SPEED_SAT)
    else $error("elapsed_zero without saturated speed");

  // one word at a time: busy right after an input is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while busy");

  // no result right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind range_average_and_speed_top ravs_checker u_ravs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
